// File: src/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Types and constants shared by the UTF-8 byte stream decoder files.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int CP_W       = 21;
  localparam int BYTE_W     = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes (selected by paddr[2])
  localparam logic REG_UTF8_MODE  = 1'b0;
  localparam logic REG_ERROR_CHAR = 1'b1;

  localparam logic             UTF8_MODE_RESET  = 1'b1;
  localparam logic [CP_W-1:0]  ERROR_CHAR_RESET = CP_W'(63);

  // Lead and continuation byte classes: (byte & MASK) == CODE
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;

  // Payload bits kept from each byte class
  localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;
  localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            char_valid;
    logic            text_done;
  } char_item_t;

  typedef struct packed {
    logic            utf8_mode;
    logic [CP_W-1:0] error_char;
  } cfg_t;

endpackage

// File: src/u8d_stream_if.sv
// ----------------------------------------------------------------------------
// u8d_stream_if
// Valid/ready stream channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface u8d_stream_if #(
  parameter type payload_t = logic [7:0]
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// File: src/u8d_cfg_regs.sv
// ----------------------------------------------------------------------------
// u8d_cfg_regs
// APB-style configuration registers: mode select and error character.
// ----------------------------------------------------------------------------
module u8d_cfg_regs
  import u8d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write registers in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.utf8_mode  <= UTF8_MODE_RESET;
      cfg.error_char <= ERROR_CHAR_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_UTF8_MODE:  cfg.utf8_mode  <= pwdata[0];
        REG_ERROR_CHAR: cfg.error_char <= pwdata[CP_W-1:0];
        default:        ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    unique case (paddr[2])
      REG_UTF8_MODE:  prdata = CFG_DATA_W'(cfg.utf8_mode);
      REG_ERROR_CHAR: prdata = CFG_DATA_W'(cfg.error_char);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: src/utf8_byte_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// Decodes a UTF-8 byte stream into 21-bit code points, or passes bytes through.
// ----------------------------------------------------------------------------
// Usage:
//   text_in carries one byte per item with an end_of_text flag on the last
//   byte of a string. char_out carries code_point, char_valid and text_done.
//   A character comes out when its last byte is accepted; continuation bytes
//   in the middle of a sequence produce no item. Bad lead bytes, malformed
//   continuation bytes and strings cut short give error_char, char_valid 0.
//   Each item is registered in the result register, or in the skid register while a result is held.
//   Throughput: one byte per cycle while char_out is taken; the sequence
//   state is one register set updated by a single mask/shift step.
//   A two-entry output buffer (result register plus skid register) keeps
//   text_in ready while one finished item waits on a stalled receiver; with
//   both entries full, text_in.ready drops until char_out is taken.
//   Reset (rst, synchronous) empties the buffer, drops any open sequence,
//   and sets utf8_mode to 1 and error_char to 63.
//   Configuration (APB, byte address 0: utf8_mode, 4: error_char) must be written
//   only while the decoder is idle; the decoder itself does not enforce this.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder
  import u8d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  u8d_stream_if.sink            text_in,
  u8d_stream_if.source          char_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;

  u8d_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequence state
  logic [1:0]      bytes_pending, bytes_pending_next;
  logic [CP_W-1:0] partial_code, partial_code_next;
  logic            sequence_bad, sequence_bad_next;

  // Output buffer
  char_item_t out_item, skid_item;
  logic       out_valid, skid_valid;

  logic       accept, pop, push;
  char_item_t res;
  logic       res_valid;

  text_item_t      item;
  logic [1:0]      pend_dec;
  logic            bad_acc;
  logic [CP_W-1:0] shifted;
  logic            started;

  assign item          = text_in.data;
  assign text_in.ready = !skid_valid;
  assign accept        = text_in.valid && text_in.ready;
  assign pop           = out_valid && char_out.ready;
  assign push          = accept && res_valid;

  assign char_out.valid = out_valid;
  assign char_out.data  = out_item;

  // Decode one byte against the current sequence state
  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_code_next  = partial_code;
    sequence_bad_next  = sequence_bad;
    res_valid          = 1'b0;
    res                = '{code_point: cfg.error_char, char_valid: 1'b0,
                           text_done: item.end_of_text};
    started            = 1'b0;
    pend_dec           = bytes_pending - 2'd1;
    bad_acc            = sequence_bad || ((item.text_byte & CONT_MASK) != CONT_CODE);
    shifted            = {partial_code[CP_W-7:0], item.text_byte[5:0] & CONT_BITS[5:0]};

    if (bytes_pending == 2'd0) begin
      priority if (!cfg.utf8_mode || !item.text_byte[7]) begin
        // Plain byte: pass through zero-extended
        res_valid       = 1'b1;
        res.code_point  = CP_W'(item.text_byte);
        res.char_valid  = 1'b1;
      end else if ((item.text_byte & LEAD2_MASK) == LEAD2_CODE) begin
        started            = 1'b1;
        bytes_pending_next = 2'd1;
        partial_code_next  = CP_W'(item.text_byte & LEAD2_BITS);
      end else if ((item.text_byte & LEAD3_MASK) == LEAD3_CODE) begin
        started            = 1'b1;
        bytes_pending_next = 2'd2;
        partial_code_next  = CP_W'(item.text_byte & LEAD3_BITS);
      end else if ((item.text_byte & LEAD4_MASK) == LEAD4_CODE) begin
        started            = 1'b1;
        bytes_pending_next = 2'd3;
        partial_code_next  = CP_W'(item.text_byte & LEAD4_BITS);
      end else begin
        // Illegal lead byte
        res_valid = 1'b1;
      end
      if (started) begin
        sequence_bad_next = 1'b0;
        // String ends right after a lead byte: drop the sequence
        if (item.end_of_text) begin
          bytes_pending_next = 2'd0;
          partial_code_next  = '0;
          res_valid          = 1'b1;
        end
      end
    end else begin
      priority if (pend_dec == 2'd0) begin
        // Sequence complete
        res_valid          = 1'b1;
        bytes_pending_next = 2'd0;
        partial_code_next  = '0;
        sequence_bad_next  = 1'b0;
        if (!bad_acc) begin
          res.code_point = shifted;
          res.char_valid = 1'b1;
        end
      end else if (item.end_of_text) begin
        // Truncated sequence
        res_valid          = 1'b1;
        bytes_pending_next = 2'd0;
        partial_code_next  = '0;
        sequence_bad_next  = 1'b0;
      end else begin
        bytes_pending_next = pend_dec;
        partial_code_next  = shifted;
        sequence_bad_next  = bad_acc;
      end
    end
  end

  // Advance sequence state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      partial_code  <= '0;
      sequence_bad  <= 1'b0;
    end else if (accept) begin
      bytes_pending <= bytes_pending_next;
      partial_code  <= partial_code_next;
      sequence_bad  <= sequence_bad_next;
    end
  end

  // Result register with skid stage; push only happens while skid is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          out_item   <= skid_item;
          skid_valid <= 1'b0;
        end else if (push) begin
          out_item <= res;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (push) begin
        if (out_valid) begin
          skid_item  <= res;
          skid_valid <= 1'b1;
        end else begin
          out_item  <= res;
          out_valid <= 1'b1;
        end
      end
    end
  end

  // Skid entry is only ever behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid without a result in the output register");

  // Pass-through mode never opens a sequence
  a_pass_no_pending: assert property (@(posedge clk) disable iff (rst)
    (accept && bytes_pending == 2'd0 && !cfg.utf8_mode) |=> bytes_pending == 2'd0)
    else $error("pass-through byte opened a sequence");

  // End of text always closes the sequence
  a_eot_closes: assert property (@(posedge clk) disable iff (rst)
    (accept && item.end_of_text) |=> (bytes_pending == 2'd0 && !sequence_bad))
    else $error("sequence left open after end of text");

  // An end-of-text byte always produces an item
  a_eot_result: assert property (@(posedge clk) disable iff (rst)
    (accept && item.end_of_text) |=> (out_valid && (skid_valid ? skid_item.text_done
                                                   : out_item.text_done)))
    else $error("end of text produced no item");

endmodule
